>>> rtl/core/hashed_call_site_counter_table_macros.svh
// Assertion macros for the hashed call-site counter table.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef HASHED_CALL_SITE_COUNTER_TABLE_MACROS_SVH
`define HASHED_CALL_SITE_COUNTER_TABLE_MACROS_SVH

// same-cycle property, checked out of reset
`define HCSCT_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies expectation in the next
`define HCSCT_CHECK_NEXT(label, cond, next_prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (next_prop)) \
      else $error(msg);

`endif

>>> rtl/core/hcsct_pkg.sv
// Package for the hashed call-site counter table: sizes, constants and types.
// No dependencies; used by every module of the block.
package hcsct_pkg;

   localparam int SLOTS       = 4096;
   localparam int IDX_W       = $clog2(SLOTS);
   localparam int PROBE_LIMIT = 64;
   localparam int PROBE_W     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SLOT_IDX_W  = 12;
   localparam int CSR_IDX_W   = 8;

   localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

   localparam logic [31:0] MIN_LENGTH_RESET    = 32'd4096;
   localparam logic [31:0] DUMP_INTERVAL_RESET = 32'd200000;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DUMP_INTERVAL = CSR_IDX_W'(1);

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [PROBE_W-1:0]    probe_type;
   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [QPTR_W-1:0]     qptr_type;
   typedef logic [QPTR_W:0]       qcount_type;

   localparam probe_type PROBE_LAST = probe_type'(PROBE_LIMIT - 1);
   localparam idx_type   IDX_LAST   = idx_type'(SLOTS - 1);

   typedef struct packed {
      logic [63:0] addr;
      logic [1:0]  ctype;
      logic [31:0] len;
      logic        is_large;
      idx_type     hash;
   } req_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic [63:0] addr;
      logic [1:0]  ctype;
      logic [63:0] calls;
      logic [63:0] bytes;
   } slot_entry_type;

endpackage

>>> rtl/core/hcsct_front.sv
// Front end: takes requests, classifies them by length and hashes large ones.
// Depends on hcsct_pkg; pushes classified requests into hcsct_queue.
module hcsct_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [63:0]              req_return_address,
   input  logic [1:0]               req_call_type,
   input  logic [31:0]              req_length,
   input  logic [31:0]              min_length,
   input  hcsct_pkg::back_status_type  back_status,
   input  hcsct_pkg::queue_status_type q_status,
   output logic                     push,
   output hcsct_pkg::req_item_type  push_item
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MUL0 = 3'd1;
   localparam logic [2:0] F_MUL1 = 3'd2;
   localparam logic [2:0] F_MUL2 = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [63:0] addr_ff;
   logic [1:0]  ctype_ff;
   logic [31:0] len_ff;
   logic        large_ff;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic        accept;

   assign req_stall = (state_ff != F_IDLE) || back_status.clearing;
   assign accept    = req_valid && !req_stall;

   // 64x64 low product split in three 32x32 partial products
   always_comb begin
      unique case (state_ff)
         F_MUL1: begin
            mul_a = addr_ff[63:32];
            mul_b = hcsct_pkg::HASH_MUL[31:0];
         end
         F_MUL2: begin
            mul_a = addr_ff[31:0];
            mul_b = hcsct_pkg::HASH_MUL[63:32];
         end
         default: begin
            mul_a = addr_ff[31:0];
            mul_b = hcsct_pkg::HASH_MUL[31:0];
         end
      endcase
   end

   assign product = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      unique case (state_ff)
         F_MUL0:  acc_in = product[63:32];
         F_MUL1:  acc_in = acc_ff + product[31:0];
         F_MUL2:  acc_in = acc_ff + product[31:0];
         default: acc_in = acc_ff;
      endcase
   end

   assign push = (state_ff == F_PUSH) && !q_status.full;

   always_comb begin
      push_item.addr     = addr_ff;
      push_item.ctype    = ctype_ff;
      push_item.len      = len_ff;
      push_item.is_large = large_ff;
      push_item.hash     = acc_ff[31 -: hcsct_pkg::IDX_W];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (req_length >= min_length) ? F_MUL0 : F_PUSH;
            end
         end
         F_MUL0: state_in = F_MUL1;
         F_MUL1: state_in = F_MUL2;
         F_MUL2: state_in = F_PUSH;
         F_PUSH: begin
            if (push) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (accept) begin
         addr_ff  <= req_return_address;
         ctype_ff <= req_call_type;
         len_ff   <= req_length;
         large_ff <= (req_length >= min_length);
      end
   end

endmodule

>>> rtl/core/hcsct_queue.sv
// Short request queue between front and back end.
// Depends on hcsct_pkg for the item type and depth.
module hcsct_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  hcsct_pkg::req_item_type     push_item,
   input  logic                        pop,
   output hcsct_pkg::req_item_type     head,
   output hcsct_pkg::queue_status_type status
);

   hcsct_pkg::req_item_type entry_ff [hcsct_pkg::QUEUE_DEPTH];
   hcsct_pkg::qptr_type     wr_ptr_ff, wr_ptr_in;
   hcsct_pkg::qptr_type     rd_ptr_ff, rd_ptr_in;
   hcsct_pkg::qcount_type   count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == hcsct_pkg::qcount_type'(hcsct_pkg::QUEUE_DEPTH));

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/hcsct_back.sv
// Back end: slot table memory, linear probe sequencer, counters, result register.
// Depends on hcsct_pkg and the assertion macro header.
`include "hashed_call_site_counter_table_macros.svh"

module hcsct_back (
   input  logic                        clock,
   input  logic                        reset,
   input  hcsct_pkg::queue_status_type q_status,
   input  hcsct_pkg::req_item_type     head,
   output logic                        pop,
   input  logic [31:0]                 dump_interval,
   output hcsct_pkg::back_status_type  status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_counted,
   output logic                        rsp_dropped,
   output logic [11:0]                 rsp_slot_index,
   output logic [63:0]                 rsp_calls_total,
   output logic [63:0]                 rsp_bytes_total,
   output logic [63:0]                 rsp_large_total,
   output logic                        rsp_dump_due
);

   localparam logic [1:0] B_IDLE  = 2'd0;
   localparam logic [1:0] B_READ  = 2'd1;
   localparam logic [1:0] B_CHECK = 2'd2;

   hcsct_pkg::slot_entry_type slot_mem [hcsct_pkg::SLOTS];
   hcsct_pkg::slot_entry_type rd_data_ff;
   hcsct_pkg::slot_entry_type mem_wdata;
   hcsct_pkg::idx_type        mem_waddr;
   logic                      mem_we;

   logic [1:0]              state_ff, state_in;
   logic                    clr_ff, clr_in;
   hcsct_pkg::idx_type      clr_idx_ff, clr_idx_in;
   hcsct_pkg::req_item_type cur_ff;
   hcsct_pkg::idx_type      h_ff, h_in;
   hcsct_pkg::probe_type    probe_ff, probe_in;
   logic [63:0]             large_ff, large_in;
   logic [31:0]             since_ff, since_in;
   logic [31:0]             since_plus;
   logic                    dump;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    counted_ff, dropped_ff, dump_ff;
   hcsct_pkg::slot_idx_type slot_idx_ff;
   logic [63:0]             calls_ff, bytes_ff, ltotal_ff;

   logic        out_free, hit, empty, found, last;
   logic        short_emit, commit, out_load;
   logic [63:0] calls_new, bytes_new;

   assign status.clearing = clr_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit      = (rd_data_ff.addr == cur_ff.addr) && (rd_data_ff.ctype == cur_ff.ctype);
   assign empty    = (rd_data_ff.addr == 64'd0);
   assign found    = hit || empty;
   assign last     = (probe_ff == hcsct_pkg::PROBE_LAST);

   assign pop = (state_ff == B_IDLE) && !clr_ff && !q_status.empty
             && (head.is_large || out_free);
   assign short_emit = pop && !head.is_large;
   assign commit     = (state_ff == B_CHECK) && (found || last) && out_free;
   assign out_load   = short_emit || commit;

   assign calls_new  = rd_data_ff.calls + 64'd1;
   assign bytes_new  = rd_data_ff.bytes + {32'd0, cur_ff.len};
   assign since_plus = since_ff + 32'd1;
   assign dump       = (since_plus >= dump_interval);

   always_comb begin
      large_in = large_ff;
      since_in = since_ff;
      if (commit) begin
         large_in = large_ff + 64'd1;
         since_in = dump ? 32'd0 : since_plus;
      end
   end

   // clearing pass has the write port until it finishes
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = h_ff;
      mem_wdata = '0;
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
      end else if (commit && found) begin
         mem_we          = 1'b1;
         mem_wdata.addr  = cur_ff.addr;
         mem_wdata.ctype = cur_ff.ctype;
         mem_wdata.calls = calls_new;
         mem_wdata.bytes = bytes_new;
      end
   end

   assign clr_in     = clr_ff && (clr_idx_ff != hcsct_pkg::IDX_LAST);
   assign clr_idx_in = clr_ff ? clr_idx_ff + 1'b1 : clr_idx_ff;

   always_comb begin
      state_in = state_ff;
      h_in     = h_ff;
      probe_in = probe_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop && head.is_large) begin
               state_in = B_READ;
               h_in     = head.hash;
               probe_in = '0;
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: begin
            if (commit) begin
               state_in = B_IDLE;
            end else if (!found && !last) begin
               state_in = B_READ;
               h_in     = h_ff + 1'b1;
               probe_in = probe_ff + 1'b1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         large_ff     <= 64'd0;
         since_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_idx_ff   <= clr_idx_in;
         large_ff     <= large_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      probe_ff <= probe_in;
      if (pop) begin
         cur_ff <= head;
      end
      if (short_emit) begin
         counted_ff  <= 1'b0;
         dropped_ff  <= 1'b0;
         slot_idx_ff <= '0;
         calls_ff    <= 64'd0;
         bytes_ff    <= 64'd0;
         ltotal_ff   <= large_ff;
         dump_ff     <= 1'b0;
      end else if (commit) begin
         counted_ff  <= 1'b1;
         dropped_ff  <= !found;
         slot_idx_ff <= found ? hcsct_pkg::slot_idx_type'(h_ff) : '0;
         calls_ff    <= found ? calls_new : 64'd0;
         bytes_ff    <= found ? bytes_new : 64'd0;
         ltotal_ff   <= large_ff + 64'd1;
         dump_ff     <= dump;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[h_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_counted     = counted_ff;
   assign rsp_dropped     = dropped_ff;
   assign rsp_slot_index  = slot_idx_ff;
   assign rsp_calls_total = calls_ff;
   assign rsp_bytes_total = bytes_ff;
   assign rsp_large_total = ltotal_ff;
   assign rsp_dump_due    = dump_ff;

   `HCSCT_CHECK(a_no_pop_in_clear, !(clr_ff && pop), "request popped during clearing pass")
   `HCSCT_CHECK(a_no_overwrite, !(rsp_valid_ff && rsp_stall && out_load), "held result overwritten")
   `HCSCT_CHECK_NEXT(a_read_to_check, state_ff == B_READ, state_ff == B_CHECK, "probe read lost")
   `HCSCT_CHECK_NEXT(a_large_step, commit, large_ff == $past(large_ff) + 64'd1, "large count off")

endmodule

>>> rtl/core/hashed_call_site_counter_table.sv
// Top level of the hashed call-site counter table: config registers and wiring.
// Depends on hcsct_pkg, hcsct_front, hcsct_queue and hcsct_back.
//
//   channel   dir  handshake              payload
//   req_      in   req_valid / req_stall  return_address, call_type, length
//   rsp_      out  rsp_valid / rsp_stall  counted .. dump_due, one per request
//   csr_      in   csr_write_enable       csr_index, csr_data
//
// A large request passes through the front in order (accept, three 32x32 partial
// products of the hash, queue push), then through the back, where each probe is a
// read state and a check state around one registered read of the slot memory, up
// to PROBE_LIMIT probes. A short request skips the hash and the probes.
// After reset the slot memory is cleared, all SLOTS (4096) entries; no request is
// taken meanwhile. A stalled result holds the back; the queue keeps the front going.
module hashed_call_site_counter_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_return_address,
   input  logic [1:0]  req_call_type,
   input  logic [31:0] req_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_counted,
   output logic        rsp_dropped,
   output logic [11:0] rsp_slot_index,
   output logic [63:0] rsp_calls_total,
   output logic [63:0] rsp_bytes_total,
   output logic [63:0] rsp_large_total,
   output logic        rsp_dump_due,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] min_length_ff, min_length_in;
   logic [31:0] dump_interval_ff, dump_interval_in;

   hcsct_pkg::back_status_type  back_status;
   hcsct_pkg::queue_status_type q_status;
   hcsct_pkg::req_item_type     push_item;
   hcsct_pkg::req_item_type     head;
   logic                        push;
   logic                        pop;

   always_comb begin
      min_length_in    = min_length_ff;
      dump_interval_in = dump_interval_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            hcsct_pkg::CSR_MIN_LENGTH:    min_length_in    = csr_data;
            hcsct_pkg::CSR_DUMP_INTERVAL: dump_interval_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff    <= hcsct_pkg::MIN_LENGTH_RESET;
         dump_interval_ff <= hcsct_pkg::DUMP_INTERVAL_RESET;
      end else begin
         min_length_ff    <= min_length_in;
         dump_interval_ff <= dump_interval_in;
      end
   end

   hcsct_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_return_address (req_return_address),
      .req_call_type      (req_call_type),
      .req_length         (req_length),
      .min_length         (min_length_ff),
      .back_status        (back_status),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item)
   );

   hcsct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   hcsct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .head            (head),
      .pop             (pop),
      .dump_interval   (dump_interval_ff),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_counted     (rsp_counted),
      .rsp_dropped     (rsp_dropped),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_calls_total (rsp_calls_total),
      .rsp_bytes_total (rsp_bytes_total),
      .rsp_large_total (rsp_large_total),
      .rsp_dump_due    (rsp_dump_due)
   );

endmodule

>>> verif/tb_hashed_call_site_counter_table.sv
// Self-checking testbench for the hashed call-site counter table.
// Scoreboard class predicts each response from a private copy of the table.
// Depends on hcsct_pkg and hashed_call_site_counter_table.
`timescale 1ns / 100ps

module tb_hashed_call_site_counter_table;
   import hcsct_pkg::*;

   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic         counted;
      logic         dropped;
      slot_idx_type slot;
      logic [63:0]  calls;
      logic [63:0]  bytes;
      logic [63:0]  large_total;
      logic         dump_due;
   } table_result_t;

   typedef struct {
      logic [63:0] addr;
      logic [1:0]  kind;
   } site_key_t;

   class call_table_scoreboard;
      logic [63:0]   site_addr [SLOTS];
      logic [1:0]    site_kind [SLOTS];
      logic [63:0]   site_calls [SLOTS];
      logic [63:0]   site_bytes [SLOTS];
      logic [63:0]   large_count;
      logic [31:0]   since_dump;
      logic [31:0]   min_len;
      logic [31:0]   dump_every;
      table_result_t pending_results[$];
      int            mismatch_count;
      int            unexpected_count;

      function new();
         foreach (site_addr[i]) begin
            site_addr[i]  = '0;
            site_kind[i]  = '0;
            site_calls[i] = '0;
            site_bytes[i] = '0;
         end
         large_count      = '0;
         since_dump       = '0;
         min_len          = MIN_LENGTH_RESET;
         dump_every       = DUMP_INTERVAL_RESET;
         mismatch_count   = 0;
         unexpected_count = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
         if (idx == CSR_MIN_LENGTH) begin
            min_len = data;
         end else if (idx == CSR_DUMP_INTERVAL) begin
            dump_every = data;
         end
      endfunction

      function void note_request(logic [63:0] addr, logic [1:0] kind, logic [31:0] len);
         table_result_t r;
         logic [63:0]   prod;
         idx_type       h;
         bit            hit;
         r = '0;
         r.large_total = large_count;
         if (len >= min_len) begin
            r.counted = 1'b1;
            prod = addr * HASH_MUL;
            h = prod[63 -: IDX_W];
            hit = 1'b0;
            for (int p = 0; p < PROBE_LIMIT && !hit; p++) begin
               if (site_addr[h] == addr && site_kind[h] == kind) begin
                  hit = 1'b1;
               end else if (site_addr[h] == 64'd0) begin
                  // zero address claims the slot but leaves it looking empty
                  site_addr[h] = addr;
                  site_kind[h] = kind;
                  hit = 1'b1;
               end else begin
                  h = (h == IDX_LAST) ? idx_type'(0) : idx_type'(h + 1'b1);
               end
            end
            if (hit) begin
               site_calls[h] = site_calls[h] + 64'd1;
               site_bytes[h] = site_bytes[h] + 64'(len);
               r.slot  = slot_idx_type'(h);
               r.calls = site_calls[h];
               r.bytes = site_bytes[h];
            end else begin
               r.dropped = 1'b1;
            end
            large_count   = large_count + 64'd1;
            r.large_total = large_count;
            since_dump    = since_dump + 32'd1;
            if (since_dump >= dump_every) begin
               since_dump = '0;
               r.dump_due = 1'b1;
            end
         end
         pending_results.push_back(r);
      endfunction

      function void check_response(table_result_t got);
         table_result_t want;
         if (pending_results.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
               $display("unexpected response: slot=%0d calls=%0d large=%0d",
                        got.slot, got.calls, got.large_total);
            end
            return;
         end
         want = pending_results.pop_front();
         if (want.counted !== got.counted || want.dropped !== got.dropped ||
             want.slot !== got.slot || want.calls !== got.calls ||
             want.bytes !== got.bytes || want.large_total !== got.large_total ||
             want.dump_due !== got.dump_due) begin
            mismatch_count++;
            if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
               $display("mismatch exp: cnt=%b drop=%b slot=%0d calls=%h bytes=%h large=%h dump=%b",
                        want.counted, want.dropped, want.slot, want.calls, want.bytes,
                        want.large_total, want.dump_due);
               $display("         got: cnt=%b drop=%b slot=%0d calls=%h bytes=%h large=%h dump=%b",
                        got.counted, got.dropped, got.slot, got.calls, got.bytes,
                        got.large_total, got.dump_due);
            end
         end
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      function int failures();
         return mismatch_count + unexpected_count + pending_results.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_return_address = '0;
   logic [1:0]  req_call_type = '0;
   logic [31:0] req_length = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_counted;
   logic        rsp_dropped;
   logic [11:0] rsp_slot_index;
   logic [63:0] rsp_calls_total;
   logic [63:0] rsp_bytes_total;
   logic [63:0] rsp_large_total;
   logic        rsp_dump_due;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   call_table_scoreboard sb;
   logic [63:0]          hash_inverse;
   site_key_t            seen_sites[$];
   int                   req_idle_pct = 0;
   int                   rsp_idle_pct = 0;
   bit                   hold_armed = 1'b0;

   hashed_call_site_counter_table u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_return_address (req_return_address),
      .req_call_type      (req_call_type),
      .req_length         (req_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_counted        (rsp_counted),
      .rsp_dropped        (rsp_dropped),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_calls_total    (rsp_calls_total),
      .rsp_bytes_total    (rsp_bytes_total),
      .rsp_large_total    (rsp_large_total),
      .rsp_dump_due       (rsp_dump_due),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_return_address, req_call_type, req_length);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response({rsp_counted, rsp_dropped, rsp_slot_index, rsp_calls_total,
                            rsp_bytes_total, rsp_large_total, rsp_dump_due});
      end
   end

   // receiver: random stalls, one long hold when armed
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < rsp_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // address whose hash lands in the given bucket
   function automatic logic [63:0] bucket_address(idx_type bucket);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return {bucket, r[63-IDX_W:0]} * hash_inverse;
   endfunction

   task automatic send_request(input logic [63:0] addr, input logic [1:0] kind,
                               input logic [31:0] len);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_return_address <= addr;
      req_call_type      <= kind;
      req_length         <= len;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic run_phase(input int count, input logic [31:0] min_value,
                            input logic [31:0] every, input int req_pct, input int rsp_pct,
                            input bit hold);
      idx_type     hot;
      site_key_t   pick;
      logic [63:0] addr;
      logic [1:0]  kind;
      logic [31:0] len;
      int          k;
      write_register(CSR_MIN_LENGTH, min_value);
      write_register(CSR_DUMP_INTERVAL, every);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      hold_armed   = hold;
      hot = idx_type'($urandom_range(SLOTS - 1, 0));
      for (int i = 0; i < count; i++) begin
         k    = $urandom_range(99, 0);
         kind = 2'($urandom_range(3, 0));
         if (k < 40 && seen_sites.size() > 0) begin
            pick = seen_sites[$urandom_range(seen_sites.size() - 1, 0)];
            addr = pick.addr;
            kind = pick.kind;
         end else if (k < 60) begin
            // pile new sites onto one bucket so probe chains run out
            addr = bucket_address(hot);
            seen_sites.push_back('{addr, kind});
         end else if (k < 64) begin
            addr = '0;
         end else begin
            addr = {$urandom, $urandom};
            seen_sites.push_back('{addr, kind});
         end
         if (min_value != 0 && $urandom_range(99, 0) < 15) begin
            len = $urandom_range(min_value - 1, 0);
         end else begin
            len = $urandom_range(32'hFFFF_FFFF, min_value);
         end
         send_request(addr, kind, len);
      end
   endtask

   initial begin
      logic [63:0] zero_bucket_site;
      hash_inverse = HASH_MUL;
      repeat (6) hash_inverse = hash_inverse * (64'd2 - HASH_MUL * hash_inverse);
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 15;
      rsp_idle_pct = 52;

      // requests around the default threshold, then the same address under each call type
      send_request(64'd1, 2'd0, 32'd0);
      send_request(64'd1, 2'd0, 32'd4095);
      send_request(64'd1, 2'd0, 32'd4096);
      send_request(64'd1, 2'd0, 32'hFFFF_FFFF);
      send_request(64'd1, 2'd1, 32'd5000);
      send_request(64'd1, 2'd2, 32'd5000);
      send_request(64'd1, 2'd3, 32'd5000);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
      // zero address: claim, hit, retype, then inherited by a real site
      send_request(64'd0, 2'd0, 32'd8000);
      send_request(64'd0, 2'd0, 32'd8000);
      send_request(64'd0, 2'd2, 32'd8000);
      zero_bucket_site = bucket_address('0);
      send_request(zero_bucket_site, 2'd1, 32'd9000);
      send_request(zero_bucket_site, 2'd1, 32'd9000);
      send_request(64'h8000_0000_0000_0000, 2'd2, 32'h8000_0000);
      send_request(64'h5555_5555_5555_5555, 2'd1, 32'h5555_5555);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 2'd2, 32'hAAAA_AAAA);

      // interval dropped below the running count
      write_register(CSR_DUMP_INTERVAL, 32'd3);
      write_register(CSR_MIN_LENGTH, 32'd0);
      repeat (4) send_request(64'd2, 2'd0, 32'd0);
      write_register(CSR_DUMP_INTERVAL, 32'd0);
      repeat (2) send_request(64'd3, 2'd1, 32'd1);
      write_register(CSR_MIN_LENGTH, 32'hFFFF_FFFF);
      write_register(CSR_DUMP_INTERVAL, 32'hFFFF_FFFF);
      send_request(64'd4, 2'd2, 32'hFFFF_FFFE);
      send_request(64'd4, 2'd2, 32'hFFFF_FFFF);

      run_phase(500, 32'd1000, 32'd7, 15, 52, 1'b1);
      run_phase(500, 32'h8000_0000, 32'd50, 52, 15, 1'b0);
      run_phase(500, 32'd0, 32'd1, 0, 0, 1'b0);

      wait_drained();
      repeat (300) @(posedge clock);
      if (sb.failures() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
